### hdl/mlm_pkg.sv
// ----------------------------------------------------------------------------
// mlm_pkg
// Shared widths, constants and types for the mean level dB meter.
// ----------------------------------------------------------------------------
`default_nettype none

package mlm_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int SUM_W           = 31;
    localparam int CNT_W           = 16;
    localparam int MAX_SAMPLES     = 32768;
    localparam int GATE_W          = 7;
    localparam int GATE_RESET      = 40;
    localparam int LEVEL_W         = 8;
    localparam int LEVEL_OFFSET    = 10;
    localparam int FRAC_W          = 16;
    localparam int MSB_W           = 5;
    localparam int LOG_W           = MSB_W + FRAC_W;
    localparam int MUL_W           = 31;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int DB_PER_LOG2_Q16 = 394566;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_acc_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_status;

endpackage

`default_nettype wire

### hdl/mlm_acc.sv
// ----------------------------------------------------------------------------
// mlm_acc
// Absolute-value sum and sample count of the current window, count saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module mlm_acc (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic                              i_last,
    input  wire logic signed [mlm_pkg::SAMPLE_W-1:0] i_sample,
    output mlm_pkg::t_acc_word                     o_next
);
    import mlm_pkg::*;

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] mag;
    logic                add_ok;

    assign mag    = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
    assign add_ok = (r_cnt < CNT_W'(MAX_SAMPLES));

    assign o_next.sum = add_ok ? (r_sum + SUM_W'(mag)) : r_sum;
    assign o_next.cnt = add_ok ? (r_cnt + 1'b1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= o_next.sum;
                r_cnt <= o_next.cnt;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mlm_mul.sv
// ----------------------------------------------------------------------------
// mlm_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mlm_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [mlm_pkg::MUL_W-1:0]    i_a,
    input  wire logic [mlm_pkg::MUL_W-1:0]    i_b,
    output logic      [mlm_pkg::PROD_W-1:0]   o_prod
);
    import mlm_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### hdl/mlm_seq.sv
// ----------------------------------------------------------------------------
// mlm_seq
// Level sequencer: log2 of sum and count by normalize and repeated squaring,
// difference scaled to dB on the shared multiplier, offset and gate compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mlm_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire mlm_pkg::t_acc_word           i_acc,
    input  wire logic [mlm_pkg::GATE_W-1:0]   i_gate,
    output mlm_pkg::t_seq_status              o_status,
    output logic signed [mlm_pkg::LEVEL_W-1:0] o_level_db,
    output logic                              o_loud
);
    import mlm_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_NORM    = 3'd1;
    localparam logic [2:0] S_SQ_MUL  = 3'd2;
    localparam logic [2:0] S_SQ_CHK  = 3'd3;
    localparam logic [2:0] S_SCL_MUL = 3'd4;
    localparam logic [2:0] S_SCL_FIN = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [MUL_W:0]     r_m, n_m;
    logic [MSB_W-1:0]   r_msb, n_msb;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [3:0]         r_iter, n_iter;
    logic               r_pass, n_pass;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LOG_W-1:0]   r_log_sum, n_log_sum;
    logic               r_neg, n_neg;
    logic [LOG_W-1:0]   r_dm, n_dm;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_loud, n_loud;
    logic               r_done, n_done;

    logic               mul_en;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  prod;
    logic [MUL_W:0]     sq;
    logic [LOG_W-1:0]   log_cur;
    logic [LOG_W:0]     diff;
    logic [LEVEL_W-1:0] p;
    logic [LEVEL_W:0]   lvl;
    logic [LEVEL_W:0]   alvl;

    assign mul_en = (r_state == S_SQ_MUL) || (r_state == S_SCL_MUL);
    assign mul_a  = (r_state == S_SCL_MUL) ? MUL_W'(r_dm) : r_m[MUL_W-1:0];
    assign mul_b  = (r_state == S_SCL_MUL) ? MUL_W'(DB_PER_LOG2_Q16) : r_m[MUL_W-1:0];

    mlm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign sq      = prod[PROD_W-1:MUL_W-1];
    assign log_cur = {r_msb, r_frac[FRAC_W-2:0], sq[MUL_W]};
    assign diff    = {1'b0, r_log_sum} - {1'b0, log_cur};
    assign p       = prod[32 +: LEVEL_W];
    assign lvl     = r_neg ? ((LEVEL_W+1)'(LEVEL_OFFSET) - {1'b0, p})
                           : ((LEVEL_W+1)'(LEVEL_OFFSET) + {1'b0, p});
    assign alvl    = lvl[LEVEL_W] ? (~lvl + 1'b1) : lvl;

    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_msb     = r_msb;
        n_frac    = r_frac;
        n_iter    = r_iter;
        n_pass    = r_pass;
        n_cnt     = r_cnt;
        n_log_sum = r_log_sum;
        n_neg     = r_neg;
        n_dm      = r_dm;
        n_level   = r_level;
        n_loud    = r_loud;
        n_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_acc.sum == '0) begin
                        n_level = '0;
                        n_loud  = (i_gate == '0);
                        n_done  = 1'b1;
                    end else begin
                        n_m     = {1'b0, i_acc.sum};
                        n_msb   = MSB_W'(MUL_W - 1);
                        n_frac  = '0;
                        n_iter  = '0;
                        n_pass  = 1'b0;
                        n_cnt   = i_acc.cnt;
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_m[MUL_W-1]) begin
                    n_state = S_SQ_MUL;
                end else begin
                    n_m   = {r_m[MUL_W-1:0], 1'b0};
                    n_msb = r_msb - 1'b1;
                end
            end
            S_SQ_MUL: begin
                n_state = S_SQ_CHK;
            end
            S_SQ_CHK: begin
                n_m     = sq[MUL_W] ? {1'b0, sq[MUL_W:1]} : sq;
                n_frac  = {r_frac[FRAC_W-2:0], sq[MUL_W]};
                n_iter  = r_iter + 1'b1;
                n_state = S_SQ_MUL;
                if (r_iter == 4'(FRAC_W - 1)) begin
                    if (!r_pass) begin
                        n_log_sum = log_cur;
                        n_m       = (MUL_W+1)'(r_cnt);
                        n_msb     = MSB_W'(MUL_W - 1);
                        n_pass    = 1'b1;
                        n_state   = S_NORM;
                    end else begin
                        n_neg   = diff[LOG_W];
                        n_dm    = diff[LOG_W] ? (~diff[LOG_W-1:0] + 1'b1) : diff[LOG_W-1:0];
                        n_state = S_SCL_MUL;
                    end
                end
            end
            S_SCL_MUL: begin
                n_state = S_SCL_FIN;
            end
            S_SCL_FIN: begin
                n_level = lvl[LEVEL_W-1:0];
                n_loud  = (alvl >= (LEVEL_W+1)'(i_gate));
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_m       <= n_m;
        r_msb     <= n_msb;
        r_frac    <= n_frac;
        r_iter    <= n_iter;
        r_pass    <= n_pass;
        r_cnt     <= n_cnt;
        r_log_sum <= n_log_sum;
        r_neg     <= n_neg;
        r_dm      <= n_dm;
        r_level   <= n_level;
        r_loud    <= n_loud;
    end

    assign o_status.busy = (r_state != S_IDLE) || r_done;
    assign o_status.done = r_done;
    assign o_level_db    = r_level;
    assign o_loud        = r_loud;

endmodule

`default_nettype wire

### hdl/pcm_mean_level_db_meter.sv
// ----------------------------------------------------------------------------
// pcm_mean_level_db_meter
// Mean absolute level of a PCM window in dB, with a loud flag.
//
// Input channel: i_valid/o_stall carry i_sample and i_last. A word is taken
// at a clock edge with i_valid high and o_stall low. Samples with i_last low
// accumulate at one per cycle unless a level is being computed, also while a
// result waits on the output. A word with i_last high starts the level
// computation: zero-sum windows give level 0 directly from idle; otherwise
// the sequencer normalizes and squares on one shared 31x31 multiplier, once
// for the sum and once for the count. o_stall is high throughout.
// Output channel: o_valid/i_stall carry o_level_db and o_loud; a result
// holds while i_stall is high, and a new last word waits until it is taken.
// i_gate_level_we writes i_gate_level; the user must assert it only while
// the block is idle, which the block does not enforce. Reset (i_rst_n low,
// synchronous) clears sum, count and pending result, sets gate level to 40.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_mean_level_db_meter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [mlm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [mlm_pkg::LEVEL_W-1:0]      o_level_db,
    output logic                                    o_loud,
    input  wire logic                               i_gate_level_we,
    input  wire logic [mlm_pkg::GATE_W-1:0]         i_gate_level
);
    import mlm_pkg::*;

    logic [GATE_W-1:0] r_gate;
    logic              r_out_valid;
    logic              accept;
    t_acc_word         acc_next;
    t_seq_status       seq_status;

    assign o_stall = seq_status.busy || (r_out_valid && i_last);
    assign accept  = i_valid && !o_stall;

    mlm_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_last),
        .i_sample (i_sample),
        .o_next   (acc_next)
    );

    mlm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && i_last),
        .i_acc      (acc_next),
        .i_gate     (r_gate),
        .o_status   (seq_status),
        .o_level_db (o_level_db),
        .o_loud     (o_loud)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= GATE_W'(GATE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_gate_level_we) begin
                r_gate <= i_gate_level;
            end
            if (seq_status.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

### hdl/mlm_chk.sv
// ----------------------------------------------------------------------------
// mlm_chk
// Port-level checks for the mean level dB meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlm_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic signed [15:0] i_sample,
    input wire logic               i_last,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [7:0]  o_level_db,
    input wire logic               o_loud,
    input wire logic               i_gate_level_we,
    input wire logic [6:0]         i_gate_level
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_level_db) && $stable(o_loud))
        else $error("stalled result word changed");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_db >= -81) && (o_level_db <= 100))
        else $error("level out of range");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("input not held after last word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last |=> !$rose(o_valid))
        else $error("result without last word");

endmodule

bind pcm_mean_level_db_meter mlm_chk u_mlm_chk (.*);

`default_nettype wire
